// ===== rtl/dqr_pkg.sv =====
package dqr_pkg;

    // Default packet store depth in bytes.
    localparam int DQR_BUFFER_BYTES = 512;

    // Fixed port widths of the payload.
    localparam int READ_INDEX_W = 9;
    localparam int REPLY_LEN_W  = 10;
    localparam int IP_W         = 32;

    // Command codes on the cmd input.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // DNS layout and limits.
    localparam int HDR_BYTES    = 12;
    localparam int MAX_LABEL    = 63;
    localparam int MAX_NAME     = 253;
    localparam int MIN_QUERY    = 17;
    localparam int ANSWER_BYTES = 16;

    // Header byte positions that the checker tests and the reply rewrites.
    localparam int POS_FLAGS_HI   = 2;
    localparam int POS_FLAGS_LO   = 3;
    localparam int POS_QDCOUNT_HI = 4;
    localparam int POS_QDCOUNT_LO = 5;
    localparam int POS_ANCOUNT_HI = 6;
    localparam int POS_ANCOUNT_LO = 7;
    localparam int POS_NSCOUNT_HI = 8;
    localparam int POS_NSCOUNT_LO = 9;
    localparam int POS_ARCOUNT_HI = 10;
    localparam int POS_ARCOUNT_LO = 11;

    // Header masks and flag bits.
    localparam logic [7:0] FLAGS_HI_MASK = 8'hF8;
    localparam logic [7:0] FLAGS_LO_MASK = 8'h0F;
    localparam logic [7:0] QR_BIT        = 8'h80;
    localparam logic [7:0] RA_BIT        = 8'h80;

    // Verdict of the query checker for the byte being pushed.
    typedef struct packed {
        logic store;
        logic accept;
        logic type_a;
    } t_dqr_push;

    // Byte of the appended A answer at the given offset.
    function automatic logic [7:0] dqr_answer_byte(input logic [3:0] off,
                                                   input logic [IP_W-1:0] ip);
        logic [7:0] b;
        case (off)
            4'd0:    b = 8'hC0;      // name pointer to the question
            4'd1:    b = 8'd12;
            4'd3:    b = 8'd1;       // type A
            4'd5:    b = 8'd1;       // class IN
            4'd11:   b = 8'd4;       // rdlength
            4'd12:   b = ip[31:24];
            4'd13:   b = ip[23:16];
            4'd14:   b = ip[15:8];
            4'd15:   b = ip[7:0];
            default: b = 8'd0;       // type/class high bytes, TTL, rdlength high
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/dqr_parser.sv =====
module dqr_parser
    import dqr_pkg::*;
#(
    parameter int BUFFER_BYTES = DQR_BUFFER_BYTES,
    localparam int CW = $clog2(BUFFER_BYTES + 2),
    localparam int AW = $clog2(BUFFER_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last,
    output logic [AW-1:0] o_wr_addr,
    output logic [CW-1:0] o_qend,
    output t_dqr_push     o_verdict
);

    // Label pointer must hold a label end past the buffer and the name limit.
    localparam int LW = (CW + 1 > 9) ? CW + 1 : 9;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LABEL  = 2'd1;
    localparam logic [1:0] PH_CLASS  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic          r_in_pkt;
    logic [CW-1:0] r_cnt, n_cnt, c_cnt;
    logic [LW-1:0] r_nl, n_nl, c_nl;
    logic [1:0]    r_phase, n_phase, c_phase;
    logic [1:0]    r_cidx, n_cidx, c_cidx;
    logic          r_bad, n_bad, c_bad;
    logic          r_tya, n_tya, c_tya;
    logic [CW-1:0] r_qend, n_qend, c_qend;
    logic [7:0]    d;

    assign d = i_data_byte;

    // The first push of a packet starts from the reset view of the state.
    always_comb begin
        c_cnt   = r_in_pkt ? r_cnt   : '0;
        c_nl    = r_in_pkt ? r_nl    : LW'(HDR_BYTES);
        c_phase = r_in_pkt ? r_phase : PH_HEADER;
        c_cidx  = r_in_pkt ? r_cidx  : 2'd0;
        c_bad   = r_in_pkt ? r_bad   : 1'b0;
        c_tya   = r_in_pkt ? r_tya   : 1'b0;
        c_qend  = r_in_pkt ? r_qend  : '0;
    end

    // Per-byte checks of the header, the label walk and the type and class.
    always_comb begin
        n_cnt   = c_cnt;
        n_nl    = c_nl;
        n_phase = c_phase;
        n_cidx  = c_cidx;
        n_bad   = c_bad;
        n_tya   = c_tya;
        n_qend  = c_qend;

        if (c_cnt >= CW'(BUFFER_BYTES)) begin
            n_bad = 1'b1;
        end
        if (c_cnt <= CW'(BUFFER_BYTES)) begin
            n_cnt = c_cnt + CW'(1);
        end

        case (c_cnt) inside
            CW'(POS_FLAGS_HI): begin
                if ((d & FLAGS_HI_MASK) != 8'd0) n_bad = 1'b1;
            end
            CW'(POS_FLAGS_LO): begin
                if ((d & FLAGS_LO_MASK) != 8'd0) n_bad = 1'b1;
            end
            CW'(POS_QDCOUNT_LO): begin
                if (d != 8'd1) n_bad = 1'b1;
            end
            CW'(POS_QDCOUNT_HI), CW'(POS_ANCOUNT_HI), CW'(POS_ANCOUNT_LO),
            CW'(POS_NSCOUNT_HI), CW'(POS_NSCOUNT_LO): begin
                if (d != 8'd0) n_bad = 1'b1;
            end
            default: ;
        endcase

        unique case (c_phase)
            PH_HEADER: begin
                if (c_cnt == CW'(HDR_BYTES - 1)) n_phase = PH_LABEL;
            end
            PH_LABEL: begin
                if (LW'(c_cnt) == c_nl) begin
                    if (d == 8'd0) begin
                        n_phase = PH_CLASS;
                        n_cidx  = 2'd0;
                    end else begin
                        if (d > 8'(MAX_LABEL)) n_bad = 1'b1;
                        n_nl = LW'(c_cnt) + LW'(1) + LW'(d[5:0]);
                        if (n_nl > LW'(HDR_BYTES + MAX_NAME)) n_bad = 1'b1;
                    end
                end
            end
            PH_CLASS: begin
                n_cidx = c_cidx + 2'd1;
                case (c_cidx)
                    2'd0: n_tya = (d == 8'd0);
                    2'd1: n_tya = c_tya && (d == 8'd1);
                    2'd2: begin
                        if (d != 8'd0) n_bad = 1'b1;
                    end
                    default: begin
                        if (d != 8'd1) n_bad = 1'b1;
                        n_phase = PH_DONE;
                        n_qend  = c_cnt + CW'(1);
                    end
                endcase
            end
            PH_DONE: ;
            default: ;
        endcase
    end

    // Verdict if this byte is the last one of the query.
    always_comb begin
        o_verdict.store  = (c_cnt < CW'(BUFFER_BYTES));
        o_verdict.type_a = n_tya;
        o_verdict.accept = !n_bad && (n_cnt >= CW'(MIN_QUERY)) && (n_phase == PH_DONE)
                           && !(n_tya && (n_qend > CW'(BUFFER_BYTES - ANSWER_BYTES)));
    end

    assign o_wr_addr = c_cnt[AW-1:0];
    assign o_qend    = n_qend;

    // Parse state advances on each pushed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pkt <= 1'b0;
            r_cnt    <= '0;
            r_nl     <= LW'(HDR_BYTES);
            r_phase  <= PH_HEADER;
            r_cidx   <= 2'd0;
            r_bad    <= 1'b0;
            r_tya    <= 1'b0;
            r_qend   <= '0;
        end else if (i_push) begin
            r_in_pkt <= !i_last;
            r_cnt    <= n_cnt;
            r_nl     <= n_nl;
            r_phase  <= n_phase;
            r_cidx   <= n_cidx;
            r_bad    <= n_bad;
            r_tya    <= n_tya;
            r_qend   <= n_qend;
        end
    end

    // A packet in progress never counts past one byte beyond the store.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(BUFFER_BYTES + 1))
        else $error("byte count past its saturation point");

    // Once the question is complete, its end lies inside the counted bytes.
    a_qend_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_pkt && r_phase == PH_DONE) |-> (r_qend <= r_cnt))
        else $error("question end beyond received bytes");

    // A rejected packet stays rejected until the next packet starts.
    a_bad_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bad && r_in_pkt) |=> (r_bad || !r_in_pkt || !$past(r_in_pkt)))
        else $error("reject flag cleared mid packet");

endmodule

// ===== rtl/dns_query_responder.sv =====
// Channel   Handshake                    Word
// --------  ---------------------------  ----------------------------------------------
// command   start, busy (accept: start   i_cmd, i_data_byte, i_last, i_read_index
//           high while busy is low)
// result    o_valid (one-cycle strobe)   o_accepted, o_reply_length, o_reply_byte
// config    i_cfg_wr_en                  i_cfg_wr_data (ip_address)
//
// One command word is taken every cycle; busy stays low. Each word gives one result
// word, through the packet store read port with the first stage and then the output
// register. The query is checked byte by byte as it is pushed, so the last push
// reports its verdict through the same registers. Reset clears the parse state and the
// reply; the packet store is not cleared. The receiver cannot stall the result channel.
module dns_query_responder
    import dqr_pkg::*;
#(
    parameter int BUFFER_BYTES = DQR_BUFFER_BYTES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_cmd,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last,
    input  logic [READ_INDEX_W-1:0] i_read_index,
    input  logic                   i_cfg_wr_en,
    input  logic [IP_W-1:0]        i_cfg_wr_data,
    output logic                   o_valid,
    output logic                   o_accepted,
    output logic [REPLY_LEN_W-1:0] o_reply_length,
    output logic [7:0]             o_reply_byte
);

    localparam int CW = $clog2(BUFFER_BYTES + 2);
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int XW = (CW > READ_INDEX_W) ? CW : READ_INDEX_W;

    logic            acc_push, acc_read;
    logic [AW-1:0]   wr_addr;
    logic [CW-1:0]   qend;
    t_dqr_push       verdict;
    logic [CW-1:0]   n_final;

    logic [IP_W-1:0] r_ip;
    logic [IP_W-1:0] r_ans_ip;
    logic [CW-1:0]   r_final_len;
    logic [CW-1:0]   r_qend;
    logic            r_type_a;

    logic [7:0]      r_mem [BUFFER_BYTES];
    logic [7:0]      r_rd_data;

    logic                    r_s1_vld;
    logic                    r_s1_read;
    logic                    r_s1_hit;
    logic [READ_INDEX_W-1:0] r_s1_idx;
    logic                    r_s1_acc;
    logic [REPLY_LEN_W-1:0]  r_s1_len;

    logic                    r_out_vld;
    logic                    r_out_acc;
    logic [REPLY_LEN_W-1:0]  r_out_len;
    logic [7:0]              r_out_byte;
    logic [7:0]              n_byte;
    logic [XW-1:0]           idx_x, qend_x, off_x;

    assign busy     = 1'b0;
    assign acc_push = start && !busy && (i_cmd == CMD_PUSH);
    assign acc_read = start && !busy && (i_cmd == CMD_READ);

    dqr_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (acc_push),
        .i_data_byte(i_data_byte),
        .i_last     (i_last),
        .o_wr_addr  (wr_addr),
        .o_qend     (qend),
        .o_verdict  (verdict)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip <= '0;
        end else if (i_cfg_wr_en) begin
            r_ip <= i_cfg_wr_data;
        end
    end

    // Reply length if the current push closes the query.
    always_comb begin
        if (!i_last || !verdict.accept) begin
            n_final = '0;
        end else if (verdict.type_a) begin
            n_final = qend + CW'(ANSWER_BYTES);
        end else begin
            n_final = qend;
        end
    end

    // Reply descriptor: any push clears it, the last push sets it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final_len <= '0;
            r_type_a    <= 1'b0;
            r_qend      <= '0;
            r_ans_ip    <= '0;
        end else if (acc_push) begin
            r_final_len <= n_final;
            r_type_a    <= i_last && verdict.accept && verdict.type_a;
            if (i_last) begin
                r_qend   <= qend;
                r_ans_ip <= r_ip;
            end
        end
    end

    // Packet store: one write port for pushes, one registered read port.
    always_ff @(posedge i_clk) begin
        if (acc_push && verdict.store) begin
            r_mem[wr_addr] <= i_data_byte;
        end
        if (acc_read) begin
            r_rd_data <= r_mem[AW'(i_read_index)];
        end
    end

    // First stage: command decode alongside the store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc_push || acc_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_push || acc_read) begin
            r_s1_read <= acc_read;
            r_s1_idx  <= i_read_index;
            r_s1_hit  <= acc_read && (XW'(i_read_index) < XW'(r_final_len));
            if (acc_read) begin
                r_s1_acc <= (r_final_len != '0);
                r_s1_len <= REPLY_LEN_W'(r_final_len);
            end else begin
                r_s1_acc <= (n_final != '0);
                r_s1_len <= REPLY_LEN_W'(n_final);
            end
        end
    end

    // Reply byte: stored query with the header rewritten and the answer appended.
    always_comb begin
        idx_x  = XW'(r_s1_idx);
        qend_x = XW'(r_qend);
        off_x  = idx_x - qend_x;
        n_byte = 8'd0;
        if (r_s1_read && r_s1_hit) begin
            if (r_type_a && (idx_x >= qend_x)) begin
                n_byte = dqr_answer_byte(off_x[3:0], r_ans_ip);
            end else begin
                case (r_s1_idx) inside
                    READ_INDEX_W'(POS_FLAGS_HI):
                        n_byte = QR_BIT | {7'd0, r_rd_data[0]};
                    READ_INDEX_W'(POS_FLAGS_LO):
                        n_byte = RA_BIT;
                    READ_INDEX_W'(POS_ANCOUNT_LO):
                        n_byte = {7'd0, r_type_a};
                    READ_INDEX_W'(POS_ARCOUNT_HI), READ_INDEX_W'(POS_ARCOUNT_LO):
                        n_byte = 8'd0;
                    default:
                        n_byte = r_rd_data;
                endcase
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_out_acc  <= r_s1_acc;
            r_out_len  <= r_s1_len;
            r_out_byte <= n_byte;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_accepted     = r_out_acc;
    assign o_reply_length = r_out_len;
    assign o_reply_byte   = r_out_byte;

    // Every taken word yields a result word through the first stage and the output register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("result word missing for a taken command");

    // A rejected query reports no reply length.
    a_reject_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_reply_length == '0))
        else $error("rejected query with nonzero length");

    // Reply data only comes from an existing reply.
    a_byte_needs_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_reply_byte != 8'd0)) |-> o_accepted)
        else $error("reply byte without a reply");

    // An A reply is the question plus the fixed-size answer.
    a_type_a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_type_a |-> (r_final_len == r_qend + CW'(ANSWER_BYTES)))
        else $error("A reply length does not match question end");

endmodule

// ===== tb/sv/dns_query_responder_tb.sv =====
`timescale 1ns / 1ps

module dns_query_responder_tb;
    import dqr_pkg::*;

    // DNS field values that the test composes and the predictor writes.
    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] CLASS_IN   = 16'd1;
    localparam logic [15:0] RDLEN_IPV4 = 16'd4;
    localparam logic [7:0]  PTR_HI     = 8'hC0;
    localparam int          IDLE_PCT   = 15;

    // One command word and one result word.
    typedef struct packed {
        logic                    cmd;
        logic [7:0]              data;
        logic                    last;
        logic [READ_INDEX_W-1:0] idx;
    } t_cmd_word;

    typedef struct packed {
        logic                   accepted;
        logic [REPLY_LEN_W-1:0] reply_length;
        logic [7:0]             reply_byte;
    } t_reply_word;

    // Ways a generated query can be malformed.
    typedef enum int {
        FLAW_NONE,
        FLAW_QR,
        FLAW_OPCODE,
        FLAW_RCODE,
        FLAW_QDCOUNT,
        FLAW_ANCOUNT,
        FLAW_NSCOUNT,
        FLAW_LONG_LABEL,
        FLAW_LABEL_OVERRUN,
        FLAW_NAME_TOO_LONG,
        FLAW_NO_END,
        FLAW_CLASS,
        FLAW_SHORT,
        FLAW_NOISE
    } t_query_flaw;

    // Shadow of the responder: packet store, parse state and the results still due.
    class t_reply_scoreboard;
        logic [7:0]      shadow_pkt [DQR_BUFFER_BYTES];
        int unsigned     bytes_in;
        bit              overflowed;
        bit              answer_a;
        bit              receiving;
        int unsigned     reply_len;
        logic [IP_W-1:0] addr;
        t_reply_word     pending[$];
        int unsigned     errors;

        function new();
            bytes_in   = 0;
            overflowed = 0;
            answer_a   = 0;
            receiving  = 0;
            reply_len  = 0;
            addr       = '0;
            errors     = 0;
        endfunction

        function void set_address(logic [IP_W-1:0] v);
            addr = v;
        endfunction

        function int unsigned reply_length();
            return reply_len;
        endfunction

        function int unsigned outstanding();
            return pending.size();
        endfunction

        // Validates the stored query and turns it into the reply; returns its length.
        function int unsigned rewrite_query();
            int unsigned len;
            int unsigned pos;
            int unsigned n;
            logic [7:0]  answer [ANSWER_BYTES];
            len = bytes_in;
            pos = HDR_BYTES;
            answer_a = 0;
            if (overflowed || len < MIN_QUERY || len > DQR_BUFFER_BYTES)
                return 0;
            if ((shadow_pkt[POS_FLAGS_HI] & FLAGS_HI_MASK) != 0 ||
                (shadow_pkt[POS_FLAGS_LO] & FLAGS_LO_MASK) != 0 ||
                shadow_pkt[POS_QDCOUNT_HI] != 0 || shadow_pkt[POS_QDCOUNT_LO] != 1 ||
                shadow_pkt[POS_ANCOUNT_HI] != 0 || shadow_pkt[POS_ANCOUNT_LO] != 0 ||
                shadow_pkt[POS_NSCOUNT_HI] != 0 || shadow_pkt[POS_NSCOUNT_LO] != 0)
                return 0;
            // Walk the labels of the question name.
            while (pos < len && shadow_pkt[pos] != 0) begin
                n = shadow_pkt[pos];
                pos++;
                if (n > MAX_LABEL || n > len - pos)
                    return 0;
                pos += n;
                if (pos - HDR_BYTES > MAX_NAME)
                    return 0;
            end
            if (pos >= len)
                return 0;
            pos++;
            if (len - pos < 4)
                return 0;
            answer_a = ({shadow_pkt[pos], shadow_pkt[pos + 1]} == TYPE_A);
            if ({shadow_pkt[pos + 2], shadow_pkt[pos + 3]} != CLASS_IN) begin
                answer_a = 0;
                return 0;
            end
            pos += 4;
            if (answer_a && DQR_BUFFER_BYTES - pos < ANSWER_BYTES) begin
                answer_a = 0;
                return 0;
            end
            // Header rewrite; the trailing records are cut off by the length.
            shadow_pkt[POS_FLAGS_HI]   = QR_BIT | (shadow_pkt[POS_FLAGS_HI] & 8'h01);
            shadow_pkt[POS_FLAGS_LO]   = RA_BIT;
            shadow_pkt[POS_ANCOUNT_LO] = {7'd0, answer_a};
            shadow_pkt[POS_ARCOUNT_HI] = 8'd0;
            shadow_pkt[POS_ARCOUNT_LO] = 8'd0;
            if (answer_a) begin
                answer = '{PTR_HI, 8'(HDR_BYTES), TYPE_A[15:8], TYPE_A[7:0],
                           CLASS_IN[15:8], CLASS_IN[7:0], 8'd0, 8'd0, 8'd0, 8'd0,
                           RDLEN_IPV4[15:8], RDLEN_IPV4[7:0],
                           addr[31:24], addr[23:16], addr[15:8], addr[7:0]};
                for (int k = 0; k < ANSWER_BYTES; k++)
                    shadow_pkt[pos + k] = answer[k];
                pos += ANSWER_BYTES;
            end
            return pos;
        endfunction

        // Applies one accepted command word and queues the result word it causes.
        function void note_command(t_cmd_word w);
            t_reply_word exp;
            exp = '0;
            if (w.cmd == CMD_PUSH) begin
                if (!receiving) begin
                    bytes_in   = 0;
                    overflowed = 0;
                    reply_len  = 0;
                    answer_a   = 0;
                    receiving  = 1;
                end
                if (bytes_in < DQR_BUFFER_BYTES)
                    shadow_pkt[bytes_in] = w.data;
                else
                    overflowed = 1;
                if (bytes_in <= DQR_BUFFER_BYTES)
                    bytes_in++;
                if (w.last) begin
                    reply_len = rewrite_query();
                    receiving = 0;
                    exp.accepted     = (reply_len != 0);
                    exp.reply_length = REPLY_LEN_W'(reply_len);
                end
            end else begin
                exp.accepted     = (reply_len != 0);
                exp.reply_length = REPLY_LEN_W'(reply_len);
                if (w.idx < reply_len && w.idx < DQR_BUFFER_BYTES)
                    exp.reply_byte = shadow_pkt[w.idx];
            end
            pending.push_back(exp);
        endfunction

        // Compares a result word with the oldest one still due.
        function void check_result(logic acc, logic [REPLY_LEN_W-1:0] len, logic [7:0] rb);
            t_reply_word exp;
            if (pending.size() == 0) begin
                $error("result word with none expected: accepted %0d, length %0d, byte %0h",
                       acc, len, rb);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (acc !== exp.accepted) begin
                $error("accepted: expected %0d, got %0d", exp.accepted, acc);
                errors++;
            end
            if (len !== exp.reply_length) begin
                $error("reply_length: expected %0d, got %0d", exp.reply_length, len);
                errors++;
            end
            if (rb !== exp.reply_byte) begin
                $error("reply_byte: expected %0h, got %0h", exp.reply_byte, rb);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_cmd;
    logic [7:0]              i_data_byte;
    logic                    i_last;
    logic [READ_INDEX_W-1:0] i_read_index;
    logic                    i_cfg_wr_en;
    logic [IP_W-1:0]         i_cfg_wr_data;
    logic                    o_valid;
    logic                    o_accepted;
    logic [REPLY_LEN_W-1:0]  o_reply_length;
    logic [7:0]              o_reply_byte;

    t_reply_scoreboard sb;
    logic [7:0]        query_bytes[$];
    bit                gaps_on;
    int unsigned       words_sent;

    dns_query_responder #(
        .BUFFER_BYTES(DQR_BUFFER_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .i_read_index  (i_read_index),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .o_accepted    (o_accepted),
        .o_reply_length(o_reply_length),
        .o_reply_byte  (o_reply_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Every result word is checked at the edge that ends its strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_result(o_accepted, o_reply_length, o_reply_byte);
    end

    function automatic t_cmd_word push_word(logic [7:0] b, logic lst);
        t_cmd_word w;
        w.cmd  = CMD_PUSH;
        w.data = b;
        w.last = lst;
        w.idx  = READ_INDEX_W'($urandom);
        return w;
    endfunction

    function automatic t_cmd_word read_word(logic [READ_INDEX_W-1:0] idx);
        t_cmd_word w;
        w.cmd  = CMD_READ;
        w.data = 8'($urandom);
        w.last = 1'($urandom);
        w.idx  = idx;
        return w;
    endfunction

    // Read position: mostly inside the reply, some at its end, some anywhere.
    function automatic logic [READ_INDEX_W-1:0] pick_index(int unsigned len);
        int unsigned r;
        int unsigned v;
        r = $urandom_range(0, 9);
        if (r < 6)
            v = (len > 0) ? $urandom_range(0, len - 1) : $urandom_range(0, 15);
        else if (r < 8)
            v = len + $urandom_range(0, 2);
        else
            v = $urandom_range(0, 511);
        if (v > 511)
            v = 511;
        return READ_INDEX_W'(v);
    endfunction

    function automatic void add_label(int unsigned n);
        query_bytes.push_back(8'(n));
        repeat (n) query_bytes.push_back(8'($urandom));
    endfunction

    // Builds one query with random content, malformed in the way that flaw names.
    function automatic void build_query(t_query_flaw flaw, bit want_a);
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [15:0] qd;
        logic [15:0] an;
        logic [15:0] ns;
        logic [15:0] cls;
        logic [15:0] qtype;
        int unsigned cut;
        int unsigned n;
        query_bytes.delete();
        if (flaw == FLAW_NOISE) begin
            repeat ($urandom_range(1, 40)) query_bytes.push_back(8'($urandom));
            return;
        end
        hi  = {5'd0, 3'($urandom)};
        lo  = {4'($urandom), 4'd0};
        qd  = 16'd1;
        an  = 16'd0;
        ns  = 16'd0;
        cls = CLASS_IN;
        case (flaw)
            FLAW_QR:      hi = hi | QR_BIT;
            FLAW_OPCODE:  hi[6:3] = 4'($urandom_range(1, 15));
            FLAW_RCODE:   lo[3:0] = 4'($urandom_range(1, 15));
            FLAW_QDCOUNT: begin
                qd = $urandom_range(0, 1) ? 16'($urandom_range(0, 255)) : 16'($urandom);
                if (qd == 16'd1)
                    qd = 16'd0;
            end
            FLAW_ANCOUNT: an = $urandom_range(0, 1) ? 16'($urandom_range(1, 255))
                                                    : 16'($urandom_range(256, 65535));
            FLAW_NSCOUNT: ns = $urandom_range(0, 1) ? 16'($urandom_range(1, 255))
                                                    : 16'($urandom_range(256, 65535));
            FLAW_CLASS: begin
                cls = 16'($urandom);
                if (cls == CLASS_IN)
                    cls = 16'd0;
            end
            default: ;
        endcase
        // Header: ID, flags, the four counts.
        query_bytes.push_back(8'($urandom));
        query_bytes.push_back(8'($urandom));
        query_bytes.push_back(hi);
        query_bytes.push_back(lo);
        query_bytes.push_back(qd[15:8]);
        query_bytes.push_back(qd[7:0]);
        query_bytes.push_back(an[15:8]);
        query_bytes.push_back(an[7:0]);
        query_bytes.push_back(ns[15:8]);
        query_bytes.push_back(ns[7:0]);
        query_bytes.push_back(8'($urandom));
        query_bytes.push_back(8'($urandom));
        // Question name.
        case (flaw)
            FLAW_LONG_LABEL: begin
                if ($urandom_range(0, 1))
                    add_label($urandom_range(1, 10));
                query_bytes.push_back(8'($urandom_range(MAX_LABEL + 1, 255)));
                repeat ($urandom_range(4, 10)) query_bytes.push_back(8'($urandom));
            end
            FLAW_NAME_TOO_LONG: begin
                repeat (3) add_label(MAX_LABEL);
                add_label(MAX_NAME - 3 * (MAX_LABEL + 1));
            end
            FLAW_LABEL_OVERRUN: begin
                // The label claims more bytes than the packet still holds.
                n = $urandom_range(8, MAX_LABEL);
                query_bytes.push_back(8'(n));
                repeat ($urandom_range(4, n - 1)) query_bytes.push_back(8'($urandom));
                return;
            end
            FLAW_NO_END: begin
                add_label($urandom_range(4, 20));
                return;
            end
            default: begin
                if ($urandom_range(0, 15) == 0) begin
                    // Name of exactly the maximum total length.
                    repeat (3) add_label(MAX_LABEL);
                    add_label(MAX_NAME - 3 * (MAX_LABEL + 1) - 1);
                end else begin
                    repeat ($urandom_range(0, 3))
                        add_label(($urandom_range(0, 7) == 0) ? MAX_LABEL
                                                              : $urandom_range(1, 10));
                end
            end
        endcase
        // Root terminator, type, class, then trailing records.
        qtype = $urandom_range(0, 1) ? 16'($urandom_range(2, 255)) : 16'($urandom);
        if (want_a)
            qtype = TYPE_A;
        query_bytes.push_back(8'd0);
        query_bytes.push_back(qtype[15:8]);
        query_bytes.push_back(qtype[7:0]);
        query_bytes.push_back(cls[15:8]);
        query_bytes.push_back(cls[7:0]);
        repeat ($urandom_range(0, 6)) query_bytes.push_back(8'($urandom));
        if (flaw == FLAW_SHORT) begin
            cut = $urandom_range(1, query_bytes.size() - 1);
            while (query_bytes.size() > cut)
                void'(query_bytes.pop_back());
        end
    endfunction

    // Offers one command word at the falling edge and holds it until taken.
    task automatic send_word(input t_cmd_word w);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= w.cmd;
        i_data_byte  <= w.data;
        i_last       <= w.last;
        i_read_index <= w.idx;
        do @(posedge i_clk); while (busy === 1'b1);
        sb.note_command(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Pushes the built query, optionally with reads slipped in between its bytes.
    task automatic push_query(input bit interleave);
        foreach (query_bytes[i]) begin
            if (interleave && $urandom_range(0, 19) == 0)
                send_word(read_word(READ_INDEX_W'($urandom)));
            send_word(push_word(query_bytes[i], i == query_bytes.size() - 1));
        end
    endtask

    // Reads some bytes of the current reply, now and then the whole of it.
    task automatic read_back();
        int unsigned len;
        len = sb.reply_length();
        if ($urandom_range(0, 7) == 0) begin
            for (int k = 0; k <= len + 1 && k < 512; k++)
                send_word(read_word(READ_INDEX_W'(k)));
        end else begin
            repeat ($urandom_range(1, 4)) send_word(read_word(pick_index(len)));
        end
    endtask

    // Lowers start and waits for every expected result word.
    task automatic drain();
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_address(input logic [IP_W-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        sb.set_address(v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned first;
        t_query_flaw flaw;
        first = words_sent;
        while (words_sent - first < budget) begin
            flaw = FLAW_NONE;
            if ($urandom_range(0, 99) >= 50)
                flaw = t_query_flaw'($urandom_range(FLAW_QR, FLAW_NOISE));
            build_query(flaw, $urandom_range(0, 3) != 0);
            push_query(1'b1);
            read_back();
        end
    endtask

    initial begin
        start         = 1'b0;
        i_cmd         = CMD_PUSH;
        i_data_byte   = 8'd0;
        i_last        = 1'b0;
        i_read_index  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_rst_n       = 1'b0;
        sb            = new();
        gaps_on       = 1;
        words_sent    = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: the shortest valid query, type A with the root name, all-ones
        // address, then reads at the first, flags, last and first-beyond reply bytes and at 511.
        write_address({IP_W{1'b1}});
        query_bytes = '{8'hFF, 8'hFF, 8'h07, 8'hF0, 8'h00, 8'h01, 8'h00, 8'h00,
                        8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00};
        query_bytes.push_back(TYPE_A[15:8]);
        query_bytes.push_back(TYPE_A[7:0]);
        query_bytes.push_back(CLASS_IN[15:8]);
        query_bytes.push_back(CLASS_IN[7:0]);
        push_query(1'b0);
        send_word(read_word(READ_INDEX_W'(0)));
        send_word(read_word(READ_INDEX_W'(POS_FLAGS_HI)));
        send_word(read_word(READ_INDEX_W'(MIN_QUERY + ANSWER_BYTES - 1)));
        send_word(read_word(READ_INDEX_W'(MIN_QUERY + ANSWER_BYTES)));
        send_word(read_word(READ_INDEX_W'(511)));

        // Random queries with gaps, zero address.
        write_address('0);
        random_traffic(260);

        // Random queries back to back with no gaps at all.
        gaps_on = 0;
        write_address(IP_W'($urandom));
        random_traffic(220);
        gaps_on = 1;

        // One more well-formed A query under a fresh address.
        write_address(IP_W'($urandom));
        build_query(FLAW_NONE, 1'b1);
        push_query(1'b1);
        read_back();

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #200000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dqr_pkg.sv
rtl/dqr_parser.sv
rtl/dns_query_responder.sv
tb/sv/dns_query_responder_tb.sv
